/* sv/shct_pkg.sv */
// Shared types and constants for the spatial hash cell table.
package shct_pkg;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [1:0] CFG_MULT_X       = 2'd1;
  localparam logic [1:0] CFG_MULT_Y       = 2'd2;
  localparam logic [1:0] CFG_MULT_Z       = 2'd3;

  localparam logic [10:0] RST_BUCKET_COUNT = 11'd1024;
  localparam logic [31:0] RST_MULT_X       = 32'd73856093;
  localparam logic [31:0] RST_MULT_Y       = 32'd19349663;
  localparam logic [31:0] RST_MULT_Z       = 32'd83492791;

  typedef struct packed {
    logic               command;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  bucket;
    logic [11:0] node;
    logic [12:0] cell_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_BRD,
    ST_BCHK,
    ST_LINK,
    ST_NRD,
    ST_NCHK
  } state_t;

endpackage

/* sv/shct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module shct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/shct_mod.sv */
// Bit-serial unsigned remainder of a 32-bit value by a variable divisor.
module shct_mod #(
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  logic [31:0]   q_r;
  logic [DW-1:0] rem_r;
  logic [5:0]    cnt_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // one dividend bit per cycle
  assign trial = {rem_r, q_r[31]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 6'd32;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[30:0], 1'b0};
      rem_r <= (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* sv/spatial_hash_cell_table.sv */
// Chained hash table of 3D grid cells: insert and lookup by signed cell coordinates.
//
//   channel   ports                            handshake
//   -------   -------------------------------  -------------------------------------
//   input     start, busy, in_data             item taken when start && !busy
//   result    out_valid, out_data              one-cycle strobe, no backpressure
//   config    cfg_we, cfg_index, cfg_wdata     write on cfg_we, no wait, no read-back
//
// Steps: an insert hashes on one shared multiplier, runs a bit-serial
//   modulo, then reads and checks the bucket, and links a chain tail if one
//   is present. A lookup then walks the chain, reading each node from node
//   memory and comparing its key, until a match or the end of the chain.
// Reset: synchronous. After reset a clearing pass writes the empty marker to
//   every bucket entry, with busy held high.
// Stalls: the receiver cannot stall; the result register frees the core, so
//   busy drops the cycle the result is strobed out.
module spatial_hash_cell_table
  import shct_pkg::*;
#(
  parameter int BUCKETS  = 1024,
  parameter int NODES    = 4096,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;  // bucket index
  localparam int NIW = (NODES > 1) ? $clog2(NODES) : 1;      // node index
  localparam int PW  = $clog2(NODES + 1);                    // pointer incl. marker
  localparam int DW  = $clog2(BUCKETS + 1);                  // divisor
  localparam int CW  = $clog2(BUCKETS + 1);                  // clear counter
  localparam int KW  = 3 * KEY_BITS;
  localparam logic [PW-1:0] MARK = PW'(NODES);

  // configuration
  logic [10:0] bucket_count_r;
  logic [31:0] mult_x_r, mult_y_r, mult_z_r;

  // control
  state_t state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r;
  logic [1:0]    hcnt_r;
  logic [PW-1:0] used_r, cur_r, steps_r, tail_r;

  // item data
  logic                cmd_r;
  logic [KEY_BITS-1:0] kx_r, ky_r, kz_r;
  logic [31:0]         prod_r, h_r;
  logic [BW-1:0]       bkt_r;

  logic      out_valid_r;
  out_item_t out_r;

  // memories
  logic          bm_we;
  logic [BW-1:0] bm_waddr;
  logic [2*PW-1:0] bm_wdata, bm_rdata;
  logic          km_we;
  logic [KW-1:0] km_rdata;
  logic          nm_we;
  logic [NIW-1:0] nm_waddr;
  logic [PW-1:0] nm_wdata, nm_rdata;

  logic [PW-1:0] b_head, b_tail;
  logic          head_empty, pool_full, accept;
  logic [KW-1:0] key;
  logic [31:0]   sx, sy, sz, ex, ey, ez, mul_a, mul_b, mul_p;
  logic [DW-1:0] eff_buckets;
  logic          div_start, div_done;
  logic [DW-1:0] div_rem;

  // result of this cycle
  logic          fin;
  status_t       fin_status;
  logic [PW-1:0] fin_node;
  logic          fin_inc;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign sx = 32'(in_data.cell_x);
  assign sy = 32'(in_data.cell_y);
  assign sz = 32'(in_data.cell_z);
  assign ex = {{(32-KEY_BITS){kx_r[KEY_BITS-1]}}, kx_r};
  assign ey = {{(32-KEY_BITS){ky_r[KEY_BITS-1]}}, ky_r};
  assign ez = {{(32-KEY_BITS){kz_r[KEY_BITS-1]}}, kz_r};
  assign key = {kz_r, ky_r, kx_r};

  assign b_head     = bm_rdata[2*PW-1:PW];
  assign b_tail     = bm_rdata[PW-1:0];
  assign head_empty = (b_head >= used_r);
  assign pool_full  = (used_r == MARK);

  // divisor: zero reads as one, large values saturate
  always_comb begin
    if (bucket_count_r == '0) begin
      eff_buckets = DW'(1);
    end else if (32'(bucket_count_r) > 32'(BUCKETS)) begin
      eff_buckets = DW'(BUCKETS);
    end else begin
      eff_buckets = DW'(bucket_count_r);
    end
  end

  // shared hash multiplier, one coordinate per cycle
  always_comb begin
    case (hcnt_r)
      2'd0:    begin mul_a = ex; mul_b = mult_x_r; end
      2'd1:    begin mul_a = ey; mul_b = mult_y_r; end
      2'd2:    begin mul_a = ez; mul_b = mult_z_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign div_start = (state_r == ST_HASH) && (hcnt_r == 2'd3);

  shct_mod #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (h_r ^ prod_r),
    .divisor  (eff_buckets),
    .done     (div_done),
    .rem      (div_rem)
  );

  // bucket entry: {head, tail}
  shct_ram #(.WIDTH(2*PW), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bkt_r),
    .rdata (bm_rdata)
  );

  shct_ram #(.WIDTH(KW), .DEPTH(NODES)) u_key_ram (
    .clk   (clk),
    .we    (km_we),
    .waddr (used_r[NIW-1:0]),
    .wdata (key),
    .raddr (cur_r[NIW-1:0]),
    .rdata (km_rdata)
  );

  shct_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (cur_r[NIW-1:0]),
    .rdata (nm_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == CW'(BUCKETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_HASH;
      ST_HASH:  if (hcnt_r == 2'd3) state_nxt = ST_MOD;
      ST_MOD:   if (div_done) state_nxt = ST_BRD;
      ST_BRD:   state_nxt = ST_BCHK;
      ST_BCHK: begin
        if (cmd_r == CMD_LOOKUP) begin
          state_nxt = ST_NRD;
        end else if (!pool_full && !head_empty && (b_tail < used_r)) begin
          state_nxt = ST_LINK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LINK:  state_nxt = ST_IDLE;
      ST_NRD: begin
        if ((cur_r < used_r) && (steps_r < MARK)) begin
          state_nxt = ST_NCHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NCHK:  state_nxt = (km_rdata == key) ? ST_IDLE : ST_NRD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    bm_we      = 1'b0;
    bm_waddr   = bkt_r;
    bm_wdata   = head_empty ? {used_r, used_r} : {b_head, used_r};
    km_we      = 1'b0;
    nm_we      = 1'b0;
    nm_waddr   = used_r[NIW-1:0];
    nm_wdata   = MARK;
    fin        = 1'b0;
    fin_status = STAT_NOT_FOUND;
    fin_node   = '0;
    fin_inc    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_cnt_r[BW-1:0];
        bm_wdata = {MARK, MARK};
      end
      ST_BCHK: begin
        if (cmd_r == CMD_INSERT) begin
          if (pool_full) begin
            fin        = 1'b1;
            fin_status = STAT_FULL;
          end else begin
            bm_we = 1'b1;
            km_we = 1'b1;
            nm_we = 1'b1;
            if (head_empty || !(b_tail < used_r)) begin
              fin        = 1'b1;
              fin_status = STAT_INSERTED;
              fin_node   = used_r;
              fin_inc    = 1'b1;
            end
          end
        end
      end
      ST_LINK: begin
        nm_we      = 1'b1;
        nm_waddr   = tail_r[NIW-1:0];
        nm_wdata   = used_r;
        fin        = 1'b1;
        fin_status = STAT_INSERTED;
        fin_node   = used_r;
        fin_inc    = 1'b1;
      end
      ST_NRD: begin
        if (!((cur_r < used_r) && (steps_r < MARK))) begin
          fin = 1'b1;
        end
      end
      ST_NCHK: begin
        if (km_rdata == key) begin
          fin        = 1'b1;
          fin_status = STAT_FOUND;
          fin_node   = cur_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      used_r         <= '0;
      out_valid_r    <= 1'b0;
      bucket_count_r <= RST_BUCKET_COUNT;
      mult_x_r       <= RST_MULT_X;
      mult_y_r       <= RST_MULT_Y;
      mult_z_r       <= RST_MULT_Z;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
      end
      if (fin_inc) begin
        used_r <= used_r + PW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata[10:0];
          CFG_MULT_X:       mult_x_r <= cfg_wdata;
          CFG_MULT_Y:       mult_y_r <= cfg_wdata;
          CFG_MULT_Z:       mult_z_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.command;
      kx_r   <= sx[KEY_BITS-1:0];
      ky_r   <= sy[KEY_BITS-1:0];
      kz_r   <= sz[KEY_BITS-1:0];
      hcnt_r <= '0;
    end
    if (state_r == ST_HASH) begin
      hcnt_r <= hcnt_r + 2'd1;
      prod_r <= mul_p;
      h_r    <= (hcnt_r == 2'd0) ? 32'd0 : (h_r ^ prod_r);
    end
    if ((state_r == ST_MOD) && div_done) begin
      bkt_r <= div_rem[BW-1:0];
    end
    if (state_r == ST_BCHK) begin
      cur_r   <= b_head;
      tail_r  <= b_tail;
      steps_r <= '0;
    end
    if ((state_r == ST_NCHK) && (km_rdata != key)) begin
      cur_r   <= nm_rdata;
      steps_r <= steps_r + PW'(1);
    end
    if (fin) begin
      out_r.status     <= fin_status;
      out_r.bucket     <= 10'(bkt_r);
      out_r.node       <= 12'(fin_node);
      out_r.cell_count <= 13'(fin_inc ? (used_r + PW'(1)) : used_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= MARK)
    else $error("node pool count past its size");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !fin && !accept)
    else $error("activity during bucket clearing pass");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STAT_INSERTED) |-> (used_r != '0))
    else $error("insert reported with empty pool");

endmodule

/* test/tb_spatial_hash_cell_table.sv */
// Testbench for spatial_hash_cell_table: directed table, random phases, closing mix.
`timescale 1ns / 100ps

module tb_spatial_hash_cell_table
  import shct_pkg::*;
();

  localparam int BUCKETS   = 1024;
  localparam int NODES     = 4096;
  localparam int NO_LINK   = NODES;    // empty marker for heads, tails and links
  localparam int QUIET_MAX = 50000;    // cycles with no item moving either way
  localparam int POOL_KEYS = 24;

  // ---------------------------------------------------------------- DUT
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_BUCKET_COUNT;
  logic [31:0] cfg_wdata = '0;

  spatial_hash_cell_table dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- table mirror
  // Copy of the registers and of the chained table, kept in step with every
  // accepted item and every register write.
  logic [10:0] div_reg;
  logic [31:0] mul_x, mul_y, mul_z;
  int          head_of [BUCKETS];
  int          tail_of [BUCKETS];
  logic [47:0] key_of  [NODES];
  int          link_of [NODES];
  int          cells_used;

  out_item_t   pending_cells[$];   // expected results, oldest first
  int          errors = 0;
  int          items_in = 0, results_out = 0;
  int          n_found = 0, n_full = 0;
  int          idle_pct = 0;
  in_item_t    key_pool [POOL_KEYS];

  function automatic out_item_t apply_cell(in_item_t it);
    logic [31:0] xs, ys, zs, h, divisor, b;
    logic [47:0] k;
    out_item_t   r;
    int          cur, steps, t;
    xs = {{16{it.cell_x[15]}}, it.cell_x};
    ys = {{16{it.cell_y[15]}}, it.cell_y};
    zs = {{16{it.cell_z[15]}}, it.cell_z};
    h  = (xs * mul_x) ^ (ys * mul_y) ^ (zs * mul_z);
    // zero divisor acts as one, above the table size it saturates
    if (div_reg == 0) divisor = 1;
    else if (div_reg > BUCKETS) divisor = BUCKETS;
    else divisor = div_reg;
    b = h % divisor;
    k = {it.cell_z, it.cell_y, it.cell_x};
    r = '0;
    r.bucket = b[9:0];
    if (it.command == CMD_INSERT) begin
      if (cells_used >= NODES) begin
        r.status = STAT_FULL;    // nothing stored, bucket still reported
      end else begin
        key_of[cells_used]  = k;
        link_of[cells_used] = NO_LINK;
        if (head_of[b] >= cells_used) begin
          head_of[b] = cells_used;
        end else begin
          t = tail_of[b];
          if (t < cells_used) link_of[t] = cells_used;
        end
        tail_of[b] = cells_used;
        r.node     = cells_used[11:0];
        r.status   = STAT_INSERTED;
        cells_used++;
      end
    end else begin
      // first match wins, so a duplicate resolves to the older node
      r.status = STAT_NOT_FOUND;
      cur   = head_of[b];
      steps = 0;
      while (cur < cells_used && steps < NODES) begin
        if (key_of[cur] == k) begin
          r.status = STAT_FOUND;
          r.node   = cur[11:0];
          break;
        end
        cur = link_of[cur];
        steps++;
      end
    end
    r.cell_count = cells_used[12:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what);
    $display("MISMATCH t=%0t %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_out++;
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = pending_cells.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", out_data.status, want.status));
        if (out_data.bucket !== want.bucket)
          report_mismatch($sformatf("bucket %0d want %0d", out_data.bucket, want.bucket));
        if (out_data.node !== want.node)
          report_mismatch($sformatf("node %0d want %0d", out_data.node, want.node));
        if (out_data.cell_count !== want.cell_count)
          report_mismatch($sformatf("cell_count %0d want %0d",
                                    out_data.cell_count, want.cell_count));
      end
    end
  end

  // Watchdog: any accepted item or result restarts the count. The clearing
  // pass after reset and the longest chain walk fit well inside.
  int quiet = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_MAX) begin
      $display("watchdog: no activity for %0d cycles", QUIET_MAX);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------- driving
  // start stays high between back-to-back items; it is lowered only ahead of
  // an idle gap, so no step sees it dropped and raised at once.
  task automatic send_cell(in_item_t it, bit typed = 0, out_item_t typed_want = '0);
    out_item_t got;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    got = apply_cell(it);
    pending_cells = {pending_cells, (typed ? typed_want : got)};
    items_in++;
    if (got.status == STAT_FOUND) n_found++;
    if (got.status == STAT_FULL) n_full++;
  endtask

  // Wait until every expected result has come in, then a short settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all four registers back to back; the block is idle here.
  task automatic set_regs(logic [31:0] bc, logic [31:0] mx, logic [31:0] my,
                          logic [31:0] mz);
    logic [31:0] v [4];
    v = '{bc, mx, my, mz};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= v[i];
      @(posedge clk);
      case (i[1:0])
        CFG_BUCKET_COUNT: div_reg = v[i][10:0];
        CFG_MULT_X:       mul_x   = v[i];
        CFG_MULT_Y:       mul_y   = v[i];
        CFG_MULT_Z:       mul_z   = v[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Six in ten random items reuse a small key set so lookups hit and inserts
  // duplicate; the rest are fully random or extreme coordinates.
  function automatic in_item_t random_cell();
    in_item_t it;
    int       sel;
    sel = $urandom_range(9);
    if (sel <= 5) begin
      it = key_pool[$urandom_range(POOL_KEYS - 1)];
    end else if (sel <= 8) begin
      it.cell_x = 16'($urandom());
      it.cell_y = 16'($urandom());
      it.cell_z = 16'($urandom());
    end else begin
      it.cell_x = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      it.cell_y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      it.cell_z = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    end
    it.command = $urandom_range(1) ? CMD_LOOKUP : CMD_INSERT;
    return it;
  endfunction

  // ---------------------------------------------------------------- directed table
  typedef struct {
    logic        cmd;
    logic [15:0] x, y, z;
    bit          typed;
    out_item_t   want;
  } cell_row_t;

  localparam int DIR_ROWS = 17;
  cell_row_t dir_tab [DIR_ROWS] = '{
    // empty table after reset; the all-zero key always hashes to bucket 0
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1, '{STAT_NOT_FOUND, 10'd0, 12'd0, 13'd0}},
    '{CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 1, '{STAT_INSERTED,  10'd0, 12'd0, 13'd1}},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1, '{STAT_FOUND,     10'd0, 12'd0, 13'd1}},
    // duplicate insert appends; lookup still returns the older node
    '{CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 1, '{STAT_INSERTED,  10'd0, 12'd1, 13'd2}},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1, '{STAT_FOUND,     10'd0, 12'd0, 13'd2}},
    // coordinate extremes
    '{CMD_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
    '{CMD_INSERT, 16'h8000, 16'h8000, 16'h8000, 0, '0},
    '{CMD_INSERT, 16'h7FFF, 16'h8000, 16'h0000, 0, '0},
    '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0},
    '{CMD_LOOKUP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
    '{CMD_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 0, '0},
    '{CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0},
    '{CMD_LOOKUP, 16'h7FFF, 16'h8000, 16'h0000, 0, '0},
    '{CMD_LOOKUP, 16'h0001, 16'h0002, 16'h0003, 0, '0},
    '{CMD_INSERT, 16'h0001, 16'hFFFF, 16'h0005, 0, '0},
    '{CMD_LOOKUP, 16'h0001, 16'hFFFF, 16'h0005, 0, '0},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0001, 0, '0}
  };

  // ---------------------------------------------------------------- sequence
  initial begin
    in_item_t it;
    int       pct_of [6] = '{0, 67, 26, 67, 0, 26};

    div_reg = RST_BUCKET_COUNT;
    mul_x = RST_MULT_X;
    mul_y = RST_MULT_Y;
    mul_z = RST_MULT_Z;
    for (int i = 0; i < BUCKETS; i++) begin
      head_of[i] = NO_LINK;
      tail_of[i] = NO_LINK;
    end
    cells_used = 0;
    for (int i = 0; i < POOL_KEYS; i++) begin
      key_pool[i].command = CMD_INSERT;
      key_pool[i].cell_x  = (i < 4) ? 16'(16'h8000 + i) : 16'($urandom_range(15) - 8);
      key_pool[i].cell_y  = 16'($urandom());
      key_pool[i].cell_z  = (i % 3 == 0) ? 16'h7FFF : 16'($urandom_range(3));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows under reset register values
    foreach (dir_tab[i]) begin
      it.command = dir_tab[i].cmd;
      it.cell_x  = dir_tab[i].x;
      it.cell_y  = dir_tab[i].y;
      it.cell_z  = dir_tab[i].z;
      send_cell(it, dir_tab[i].typed, dir_tab[i].want);
    end

    // random phases; settings cover divisor one, zero, saturation, masking
    // of the upper write bits, zero and all-ones multipliers
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(1, RST_MULT_X, RST_MULT_Y, RST_MULT_Z);
        1: set_regs(0, 0, 0, 0);
        2: set_regs(2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_regs(7, $urandom(), $urandom(), $urandom());
        4: set_regs(32'hFFFF_F400, $urandom(), $urandom(), $urandom());
        default: set_regs($urandom_range(1, 1024), $urandom(), 32'h0, $urandom());
      endcase
      idle_pct = pct_of[ph];
      repeat (122) send_cell(random_cell());
    end

    // closing mix under reset register values, ending on a duplicate insert
    set_regs(RST_BUCKET_COUNT, RST_MULT_X, RST_MULT_Y, RST_MULT_Z);
    idle_pct = 26;
    repeat (16) send_cell(random_cell());
    it = key_pool[0];
    it.command = CMD_INSERT;
    send_cell(it);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d results: %0d lookups hit, %0d inserts refused full",
             items_in, results_out, n_found, n_full);
    $display("directed table plus six register settings incl. divisor 0/1/saturated, %0d nodes",
             cells_used);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
